// File: rtl/core/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Types and constants shared by the text console controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tccs_pkg;

  // Input word: one console command
  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
    logic [10:0] cell_index;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [15:0] read_data;
    logic [10:0] cursor_pos;
  } out_word_t;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_BLANK = 8'h20;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7F;

  localparam logic [7:0] ATTR_RESET = 8'h02;
  localparam int unsigned TAB_STEP  = 4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ,
    ST_RDATA,
    ST_COMMIT,
    ST_SCROLL,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic decode;
    logic commit;
    logic sweep;
    logic sweep_zero;
    logic emit;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
    logic scroll;
    logic sweep_last;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/tccs_ctrl.sv
// ----------------------------------------------------------------------------
// tccs_ctrl
// Sequencer for the console: clear pass, decode, cell read, commit, scroll sweep, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire tccs_pkg::dp_status_t status,
  output tccs_pkg::ctrl_cmd_t     cmd
);

  tccs_pkg::state_t state_r;
  tccs_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tccs_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      tccs_pkg::ST_CLEAR: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_zero = 1'b1;
        if (status.sweep_last) state_nxt = tccs_pkg::ST_IDLE;
      end
      tccs_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = tccs_pkg::ST_DECODE;
        end
      end
      tccs_pkg::ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = status.is_read ? tccs_pkg::ST_READ : tccs_pkg::ST_COMMIT;
      end
      tccs_pkg::ST_READ: begin
        state_nxt = tccs_pkg::ST_RDATA;
      end
      tccs_pkg::ST_RDATA: begin
        cmd.emit  = 1'b1;
        state_nxt = tccs_pkg::ST_IDLE;
      end
      tccs_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = status.scroll ? tccs_pkg::ST_SCROLL : tccs_pkg::ST_EMIT;
      end
      tccs_pkg::ST_SCROLL: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) state_nxt = tccs_pkg::ST_EMIT;
      end
      tccs_pkg::ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = tccs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tccs_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/tccs_datapath.sv
// ----------------------------------------------------------------------------
// tccs_datapath
// Cell memory, cursor registers, put-character decode and the sweep engine
// that clears the grid or moves it up one row.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_datapath #(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [7:0]           cfg_wdata,
  input  wire tccs_pkg::in_word_t   in_word,
  input  wire tccs_pkg::ctrl_cmd_t  cmd,
  output tccs_pkg::dp_status_t      status,
  output logic                      out_valid,
  output tccs_pkg::out_word_t       out_word
);

  localparam int unsigned TAB_STEP_L = tccs_pkg::TAB_STEP;
  localparam int unsigned CELLS  = ROWS * COLS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned ROW_W  = $clog2(ROWS + 1);
  localparam int unsigned COL_W  = $clog2(COLS + TAB_STEP_L);
  localparam int unsigned POS_W  = (ADDR_W > 11) ? ADDR_W : 11;

  // Cell memory
  logic [15:0]       mem [CELLS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [15:0]       rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[mem_raddr];
  end

  // Attribute register
  logic [7:0] attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= tccs_pkg::ATTR_RESET;
    end else if (cfg_we) begin
      attr_r <= cfg_wdata;
    end
  end

  // Latched item and cursor
  tccs_pkg::in_word_t item_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_word;
  end

  // Put-character decode
  logic [ROW_W-1:0]  r1;
  logic [COL_W-1:0]  c1;
  logic              wr;
  logic [ROW_W-1:0]  wr_row;
  logic [COL_W-1:0]  wr_col;
  logic [7:0]        wr_ch;
  logic              scroll;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       idx_ext;
  logic              oob;

  always_comb begin
    r1     = row_r;
    c1     = col_r;
    wr     = 1'b0;
    wr_ch  = item_r.char_code;
    scroll = 1'b0;
    priority if (item_r.char_code == tccs_pkg::CHAR_BS) begin
      if (col_r != '0) begin
        c1 = col_r - COL_W'(1);
      end else begin
        if (row_r != '0) r1 = row_r - ROW_W'(1);
        c1 = COL_W'(COLS - 1);
      end
      wr    = 1'b1;
      wr_ch = tccs_pkg::CHAR_BLANK;
    end else if (item_r.char_code == tccs_pkg::CHAR_TAB) begin
      c1 = (col_r + COL_W'(TAB_STEP_L)) & ~COL_W'(TAB_STEP_L - 1);
    end else if (item_r.char_code == tccs_pkg::CHAR_CR) begin
      c1 = '0;
    end else if (item_r.char_code == tccs_pkg::CHAR_LF) begin
      c1 = '0;
      r1 = row_r + ROW_W'(1);
    end else if (item_r.char_code >= tccs_pkg::PRINT_LO &&
                 item_r.char_code <= tccs_pkg::PRINT_HI) begin
      wr = 1'b1;
      c1 = col_r + COL_W'(1);
    end else begin
      // other control bytes and high bytes leave the cursor alone
      c1 = col_r;
    end
    // backspace writes at the moved cursor, a printable byte at the old one
    wr_row = (item_r.char_code == tccs_pkg::CHAR_BS) ? r1 : row_r;
    wr_col = (item_r.char_code == tccs_pkg::CHAR_BS) ? c1 : col_r;
    if (c1 >= COL_W'(COLS)) begin
      c1 = '0;
      r1 = r1 + ROW_W'(1);
    end
    if (r1 >= ROW_W'(ROWS)) begin
      r1     = ROW_W'(ROWS - 1);
      scroll = 1'b1;
    end
  end

  assign wr_addr = ADDR_W'(wr_row) * ADDR_W'(COLS) + ADDR_W'(wr_col);
  assign idx_ext = 32'(item_r.cell_index);
  assign oob     = idx_ext >= 32'(CELLS);

  // Decode stage registers
  logic              wr_en_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [15:0]       wr_data_r;
  logic [ROW_W-1:0]  new_row_r;
  logic [COL_W-1:0]  new_col_r;
  logic              scroll_r;
  logic              oob_r;
  logic [ADDR_W-1:0] raddr_r;

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      wr_en_r   <= wr && (item_r.op == tccs_pkg::OP_PUT);
      wr_addr_r <= wr_addr;
      wr_data_r <= {attr_r, wr_ch};
      new_row_r <= r1;
      new_col_r <= c1;
      scroll_r  <= scroll;
      oob_r     <= oob;
      raddr_r   <= oob ? '0 : idx_ext[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.commit) begin
      row_r <= new_row_r;
      col_r <= new_col_r;
    end
  end

  // Sweep engine: read cell cnt+COLS, write it to cnt in the next cycle;
  // the bottom row (or every cell in a clear pass) gets zero.
  logic [ADDR_W-1:0] cnt_r;
  logic [ADDR_W:0]   src;
  logic              zero_region;
  logic              dly_vld_r;
  logic [ADDR_W-1:0] dly_addr_r;
  logic              dly_zero_r;

  assign src         = {1'b0, cnt_r} + (ADDR_W + 1)'(COLS);
  assign zero_region = cmd.sweep_zero || (cnt_r >= ADDR_W'(CELLS - COLS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      dly_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cmd.sweep ? cnt_r + ADDR_W'(1) : '0;
      dly_vld_r <= cmd.sweep;
    end
  end

  always_ff @(posedge clk) begin
    dly_addr_r <= cnt_r;
    dly_zero_r <= zero_region;
  end

  always_comb begin
    if (cmd.sweep) begin
      mem_raddr = zero_region ? '0 : src[ADDR_W-1:0];
    end else begin
      mem_raddr = raddr_r;
    end
    if (dly_vld_r) begin
      mem_we    = 1'b1;
      mem_waddr = dly_addr_r;
      mem_wdata = dly_zero_r ? 16'h0000 : rd_data_r;
    end else begin
      mem_we    = cmd.commit && wr_en_r;
      mem_waddr = wr_addr_r;
      mem_wdata = wr_data_r;
    end
  end

  assign status.is_read    = (item_r.op == tccs_pkg::OP_READ);
  assign status.scroll     = scroll_r;
  assign status.sweep_last = (cnt_r == ADDR_W'(CELLS - 1));

  // Result register
  logic [POS_W-1:0]    pos;
  logic                out_valid_r;
  tccs_pkg::out_word_t out_word_r;

  assign pos = POS_W'(row_r) * POS_W'(COLS) + POS_W'(col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word_r.read_data  <= (item_r.op == tccs_pkg::OP_READ && !oob_r) ?
                               rd_data_r : 16'h0000;
      out_word_r.cursor_pos <= pos[10:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// File: rtl/core/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console engine: ROWS x COLS grid of attribute/character cells with a
// cursor, put-character handling with wrap and scroll, and cell read-back.
// ----------------------------------------------------------------------------
//  channel   ports                        handshake
//  input     start, busy, in_word         taken when start && !busy
//  result    out_valid, out_word          one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_wdata            attribute byte, written on cfg_we
//
//  A read word passes the decode and memory read states, a put word the
//  decode and commit states; then the result is emitted. busy drops with
//  the strobe, so no new word is taken before the last word's result is
//  out.
//  A put word that scrolls adds a sweep over every cell: the sweep moves one
//  cell per cycle, reading one row ahead and writing in the cycle after.
//  After reset busy stays high for a clearing pass over every cell; the
//  last cell is zeroed in the first idle cycle. Results cannot be stalled by
//  the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll #(
  parameter int unsigned ROWS = 25,
  parameter int unsigned COLS = 80
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire tccs_pkg::in_word_t  in_word,
  output logic                     out_valid,
  output tccs_pkg::out_word_t      out_word,
  input  wire logic                cfg_we,
  input  wire logic [7:0]          cfg_wdata
);

  tccs_pkg::ctrl_cmd_t  cmd;
  tccs_pkg::dp_status_t status;

  tccs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  tccs_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// File: sim/text_console_cursor_scroll_tb.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_tb
// Self-checking bench for the text console engine. A model of the cell grid,
// the cursor and the attribute register predicts the result of every
// accepted word. Directed checks cover control bytes, wrap and scroll. A long
// random run with bursty input and attribute changes between phases follows.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROWS       = 25;
  localparam int unsigned COLS       = 80;
  localparam int unsigned CELLS      = ROWS * COLS;
  localparam int unsigned IDLE_LIMIT = 20000;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_ESC     = 8'h1B;
  localparam logic [7:0] CHAR_US      = 8'h1F;
  localparam logic [7:0] CHAR_HI_LO   = 8'h80;
  localparam logic [7:0] CHAR_HI_HI   = 8'hFF;
  localparam logic [7:0] ATTR_MIN     = 8'h00;
  localparam logic [7:0] ATTR_MAX     = 8'hFF;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                start     = 1'b0;
  logic                busy;
  tccs_pkg::in_word_t  in_word   = '0;
  logic                out_valid;
  tccs_pkg::out_word_t out_word;
  logic                cfg_we    = 1'b0;
  logic [7:0]          cfg_wdata = '0;

  // console model
  logic [15:0] screen_model [CELLS];
  logic [4:0]  cur_row;
  logic [6:0]  cur_col;
  logic [7:0]  attr_model;

  tccs_pkg::out_word_t pending_results [$];

  int err_count    = 0;
  int put_count    = 0;
  int read_count   = 0;
  int scroll_count = 0;
  int attr_writes  = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;
  bit pacing       = 1'b0;

  text_console_cursor_scroll #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic tccs_pkg::out_word_t predict_console(tccs_pkg::in_word_t w);
    tccs_pkg::out_word_t r;
    int unsigned         pos;
    r = '0;
    if (w.op == tccs_pkg::OP_PUT) begin
      put_count++;
      if (w.char_code == tccs_pkg::CHAR_BS) begin
        if (cur_col != 0) begin
          cur_col--;
        end else begin
          if (cur_row != 0) cur_row--;
          cur_col = 7'(COLS - 1);
        end
        screen_model[cur_row * COLS + cur_col] = {attr_model, tccs_pkg::CHAR_BLANK};
      end else if (w.char_code == tccs_pkg::CHAR_TAB) begin
        cur_col = (cur_col + 7'(tccs_pkg::TAB_STEP)) & ~7'(tccs_pkg::TAB_STEP - 1);
      end else if (w.char_code == tccs_pkg::CHAR_CR) begin
        cur_col = '0;
      end else if (w.char_code == tccs_pkg::CHAR_LF) begin
        cur_col = '0;
        cur_row++;
      end else if (w.char_code >= tccs_pkg::PRINT_LO &&
                   w.char_code <= tccs_pkg::PRINT_HI) begin
        screen_model[cur_row * COLS + cur_col] = {attr_model, w.char_code};
        cur_col++;
      end
      if (cur_col >= COLS) begin
        cur_col = '0;
        cur_row++;
      end
      // shift the grid up one row and blank the bottom row
      if (cur_row >= ROWS) begin
        scroll_count++;
        for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_model[i] = screen_model[i + COLS];
        for (int i = (ROWS - 1) * COLS; i < CELLS; i++) screen_model[i] = '0;
        cur_row = 5'(ROWS - 1);
      end
    end else begin
      read_count++;
      if (w.cell_index < CELLS) r.read_data = screen_model[w.cell_index];
    end
    pos = cur_row * COLS + cur_col;
    r.cursor_pos = pos[10:0];
    return r;
  endfunction

  // result checker: results cannot be held off, take each strobe as it comes
  always @(posedge clk) begin
    tccs_pkg::out_word_t exp_word;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: read_data %h cursor_pos %0d",
               out_word.read_data, out_word.cursor_pos);
        err_count++;
      end else begin
        exp_word = pending_results.pop_front();
        if (out_word.read_data !== exp_word.read_data) begin
          $error("read_data expected %h got %h", exp_word.read_data, out_word.read_data);
          err_count++;
        end
        if (out_word.cursor_pos !== exp_word.cursor_pos) begin
          $error("cursor_pos expected %0d got %0d", exp_word.cursor_pos, out_word.cursor_pos);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic pace_sender();
    int gap;
    if (pacing) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = $urandom_range(1, 12);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(0, 30);
      end
    end
  endtask

  // drive one word and hold it until the block takes it
  task automatic send_word(input logic op, input logic [7:0] ch, input logic [10:0] idx);
    tccs_pkg::in_word_t w;
    w.op = op;
    w.char_code = ch;
    w.cell_index = idx;
    pace_sender();
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_console(w));
  endtask

  task automatic put_char(input logic [7:0] ch);
    send_word(tccs_pkg::OP_PUT, ch, 11'($urandom_range(0, 2047)));
  endtask

  task automatic read_cell(input logic [10:0] idx);
    send_word(tccs_pkg::OP_READ, 8'($urandom), idx);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // attribute changes only with nothing in flight
  task automatic write_attr(input logic [7:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    attr_model = value;
    attr_writes++;
    cfg_we    <= 1'b0;
  endtask

  task automatic test_reset_and_controls();
    read_cell(11'd0);
    read_cell(11'(CELLS - 1));
    read_cell(11'(CELLS));
    read_cell(11'h7FF);
    put_char(tccs_pkg::CHAR_BS);        // backspace at origin: last column, row 0
    read_cell(11'(COLS - 1));
    put_char("A");                      // wraps to next row
    put_char(tccs_pkg::CHAR_BLANK);
    put_char(tccs_pkg::PRINT_HI);
    put_char("z");
    put_char(tccs_pkg::CHAR_BS);
    put_char(tccs_pkg::CHAR_TAB);
    put_char(tccs_pkg::CHAR_TAB);
    put_char(CHAR_NUL);
    put_char(CHAR_ESC);
    put_char(CHAR_US);
    put_char(CHAR_HI_LO);
    put_char(CHAR_HI_HI);
    put_char(8'hC1);
    put_char(tccs_pkg::CHAR_CR);
    put_char(tccs_pkg::CHAR_LF);
    read_cell(11'(COLS));
    read_cell(11'(COLS + 1));
    read_cell(11'(COLS + 3));
  endtask

  task automatic test_wrap_and_scroll();
    repeat (ROWS + 2) put_char(tccs_pkg::CHAR_LF);
    put_char(tccs_pkg::CHAR_CR);
    repeat (COLS / tccs_pkg::TAB_STEP) put_char(tccs_pkg::CHAR_TAB);   // last tab wraps
    put_char(tccs_pkg::CHAR_CR);
    repeat (COLS / tccs_pkg::TAB_STEP - 1) put_char(tccs_pkg::CHAR_TAB);
    repeat (tccs_pkg::TAB_STEP) put_char("#");     // last one wraps and scrolls
    put_char(tccs_pkg::CHAR_CR);
    put_char(tccs_pkg::CHAR_BS);        // backspace at column 0 steps a row back
    read_cell(11'((ROWS - 1) * COLS - 1));
    read_cell(11'((ROWS - 1) * COLS));
    read_cell(11'((ROWS - 2) * COLS + COLS - 4));
  endtask

  task automatic test_attribute_extremes();
    write_attr(ATTR_MIN);
    put_char("m");
    put_char(tccs_pkg::CHAR_BS);
    write_attr(ATTR_MAX);
    wait_drained();
    put_char("M");
    put_char(tccs_pkg::CHAR_BS);
    read_cell(11'((ROWS - 1) * COLS));
    wait_drained();
    write_attr(8'($urandom));
    put_char("r");
  endtask

  task automatic test_random_traffic(input int n_items);
    int pick;
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      case (phase)
        0:       write_attr(tccs_pkg::ATTR_RESET);
        3:       write_attr(ATTR_MIN);
        5:       write_attr(ATTR_MAX);
        default: write_attr(8'($urandom));
      endcase
      pacing = (phase % 3 != 0);
      burst_left = 0;
      for (int i = 0; i < n_items / 8; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) put_char(8'($urandom_range(tccs_pkg::PRINT_LO, tccs_pkg::PRINT_HI)));
        else if (pick < 61) put_char(tccs_pkg::CHAR_LF);
        else if (pick < 64) put_char(tccs_pkg::CHAR_CR);
        else if (pick < 69) put_char(tccs_pkg::CHAR_TAB);
        else if (pick < 75) put_char(tccs_pkg::CHAR_BS);
        else if (pick < 80) put_char(8'($urandom));
        else if (pick < 95) read_cell(11'($urandom_range(0, CELLS - 1)));
        else read_cell(11'($urandom_range(0, 2047)));
      end
    end
  endtask

  initial begin
    foreach (screen_model[i]) screen_model[i] = '0;
    cur_row    = '0;
    cur_col    = '0;
    attr_model = tccs_pkg::ATTR_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_and_controls();
    test_wrap_and_scroll();
    test_attribute_extremes();
    test_random_traffic(2000);

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Covered %0d put words and %0d read words, %0d scrolls, %0d attribute writes.",
             put_count, read_count, scroll_count, attr_writes);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
